### rtl/segsum_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// No dependencies; used by segment_tree_range_sum and segsum_checker.
package segsum_pkg;

    localparam int DATA_W = 32;   // element and sum width
    localparam int IDX_W  = 10;   // element index width on the ports
    localparam int SIZE_W = 11;   // size register width

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,   // zero the node memory after reset
        S_IDLE,    // ready for an input word
        S_START,   // decode the latched word
        S_UPD,     // recompute sums from leaf to root
        S_QRUN,    // walk the range, accumulate
        S_OUT      // hand the result to the output register
    } t_state;

endpackage

### rtl/segment_tree_range_sum.sv
// Segment tree of partial sums with point update and circular range-sum query.
// Depends on segsum_pkg. Node sums live in one 1W2R synchronous memory.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per item: i_mode selects
//   a point update (i_position, i_new_value) or a range query (i_left_bound,
//   i_right_bound). An update gives no output word; a query gives exactly one
//   word on the output channel (o_out_valid / i_out_stall): o_range_sum and
//   o_bound_error. A query with left above right wraps around the size in use.
//   i_cfg_we / i_cfg_data write the size in use; write only while idle.
//
// Sequence after a word is accepted (S_START, then per mode):
//   update : S_START writes the leaf, then S_UPD writes one node per level
//            up to the root; the next word is taken after that.
//   query  : S_QRUN walks the range, then S_OUT hands over the result and
//            the next word can follow; a wrapped range walks two spans.
//            Each span reads one tree level at a time on the memory's two
//            read ports, plus one closing step.
//   A bound error goes from S_START straight to S_OUT.
//   One item is processed at a time; o_in_stall is low only in the idle state.
//
// Reset: synchronous, active low. Afterwards the node memory is cleared one
//   entry a cycle, all 2*LEAVES entries, with o_in_stall high; configuration
//   writes are taken during that time. The size register resets to 1024.
// Output stall: the result sits in an output register. The next item is
//   accepted while it waits; a second query result waits in the block until
//   the output register frees up.
module segment_tree_range_sum #(
    parameter int LEAVES = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_mode,
    input  logic        [segsum_pkg::IDX_W-1:0]    i_position,
    input  logic signed [segsum_pkg::DATA_W-1:0]   i_new_value,
    input  logic        [segsum_pkg::IDX_W-1:0]    i_left_bound,
    input  logic        [segsum_pkg::IDX_W-1:0]    i_right_bound,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [segsum_pkg::DATA_W-1:0]   o_range_sum,
    output logic                                   o_bound_error,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic        [segsum_pkg::SIZE_W-1:0]   i_cfg_data
);

    localparam int LW = $clog2(LEAVES);
    localparam int AW = $clog2(2 * LEAVES);          // node address width
    localparam int BW = AW + 1;                       // walk bound, holds 2*LEAVES
    localparam int NW = (LW + 1 > segsum_pkg::SIZE_W) ? LW + 1 : segsum_pkg::SIZE_W;
    localparam int DW = segsum_pkg::DATA_W;
    localparam int IW = segsum_pkg::IDX_W;
    localparam int SW = segsum_pkg::SIZE_W;

    localparam logic [AW-1:0] LEAF_BASE   = AW'(LEAVES);
    localparam logic [BW-1:0] LEAF_BASE_W = BW'(LEAVES);
    localparam logic [AW-1:0] ROOT_NODE   = AW'(1);
    localparam logic [AW-1:0] CLR_LAST    = AW'(2 * LEAVES - 1);
    localparam logic [NW-1:0] LEAVES_N    = NW'(LEAVES);

    // control
    segsum_pkg::t_state r_state, n_state;
    logic [AW-1:0]      r_clr, n_clr;
    logic [SW-1:0]      r_size, n_size;
    logic               r_out_valid, n_out_valid;

    // latched input word
    logic               r_mode, n_mode;
    logic [IW-1:0]      r_pos, n_pos;
    logic [DW-1:0]      r_val, n_val;
    logic [IW-1:0]      r_lo, n_lo;
    logic [IW-1:0]      r_hi, n_hi;

    // walk state
    logic [AW-1:0]      r_p, n_p;         // update: node just written
    logic [DW-1:0]      r_acc, n_acc;     // running sum
    logic [BW-1:0]      r_a, n_a;         // query: half-open range [a, b)
    logic [BW-1:0]      r_b, n_b;
    logic               r_va, n_va;       // read data on port a counts
    logic               r_vb, n_vb;       // read data on port b counts
    logic               r_second, n_second; // wrapped query: low span still to do

    // result and output register
    logic [DW-1:0]      r_res_sum, n_res_sum;
    logic               r_res_err, n_res_err;
    logic [DW-1:0]      r_out_sum, n_out_sum;
    logic               r_out_err, n_out_err;

    // node memory
    logic [DW-1:0]      mem_nodes [0:2*LEAVES-1];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [DW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_ra;
    logic [AW-1:0]      mem_rb;
    logic [DW-1:0]      r_rd_a;
    logic [DW-1:0]      r_rd_b;

    // datapath helpers
    logic [NW-1:0]      size_ext;
    logic [NW-1:0]      n_use;       // size in use, capped at LEAVES
    logic               pos_ok;
    logic               bound_bad;
    logic               wrap;
    logic [AW-1:0]      leaf_addr;
    logic [AW-1:0]      parent;
    logic [DW-1:0]      upd_sum;
    logic [DW-1:0]      acc_sum;
    logic [BW-1:0]      b_dec;

    assign size_ext  = NW'(r_size);
    assign n_use     = (size_ext > LEAVES_N) ? LEAVES_N : size_ext;
    assign pos_ok    = NW'(r_pos) < n_use;
    assign bound_bad = (NW'(r_lo) >= n_use) || (NW'(r_hi) >= n_use);
    assign wrap      = r_lo > r_hi;
    assign leaf_addr = LEAF_BASE + AW'(r_pos);
    assign parent    = r_p >> 1;
    assign upd_sum   = r_acc + r_rd_a;
    assign acc_sum   = r_acc + (r_va ? r_rd_a : '0) + (r_vb ? r_rd_b : '0);
    assign b_dec     = r_b - BW'(1);

    assign o_in_stall    = (r_state != segsum_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_range_sum   = r_out_sum;
    assign o_bound_error = r_out_err;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_size      = i_cfg_we ? i_cfg_data : r_size;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_p         = r_p;
        n_acc       = r_acc;
        n_a         = r_a;
        n_b         = r_b;
        n_va        = r_va;
        n_vb        = r_vb;
        n_second    = r_second;
        n_res_sum   = r_res_sum;
        n_res_err   = r_res_err;
        n_out_sum   = r_out_sum;
        n_out_err   = r_out_err;
        mem_we      = 1'b0;
        mem_waddr   = r_clr;
        mem_wdata   = '0;
        mem_ra      = r_a[AW-1:0];
        mem_rb      = b_dec[AW-1:0];

        // output word taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            segsum_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = segsum_pkg::S_IDLE;
                end
            end
            segsum_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_pos   = i_position;
                    n_val   = i_new_value;
                    n_lo    = i_left_bound;
                    n_hi    = i_right_bound;
                    n_state = segsum_pkg::S_START;
                end
            end
            segsum_pkg::S_START: begin
                if (r_mode == segsum_pkg::MODE_UPDATE) begin
                    if (pos_ok) begin
                        // write the leaf, fetch its sibling
                        mem_we    = 1'b1;
                        mem_waddr = leaf_addr;
                        mem_wdata = r_val;
                        mem_ra    = leaf_addr ^ AW'(1);
                        n_p       = leaf_addr;
                        n_acc     = r_val;
                        n_state   = segsum_pkg::S_UPD;
                    end else begin
                        n_state = segsum_pkg::S_IDLE;
                    end
                end else if (bound_bad) begin
                    n_res_sum = '0;
                    n_res_err = 1'b1;
                    n_state   = segsum_pkg::S_OUT;
                end else begin
                    // wrapped: [lo, size-1] first, then [0, hi]
                    n_a      = LEAF_BASE_W + BW'(r_lo);
                    n_b      = wrap ? (LEAF_BASE_W + BW'(n_use))
                                    : (LEAF_BASE_W + BW'(r_hi) + BW'(1));
                    n_second = wrap;
                    n_acc    = '0;
                    n_va     = 1'b0;
                    n_vb     = 1'b0;
                    n_state  = segsum_pkg::S_QRUN;
                end
            end
            segsum_pkg::S_UPD: begin
                // parent = this node + sibling; fetch the parent's sibling meanwhile
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = upd_sum;
                mem_ra    = parent ^ AW'(1);
                n_p       = parent;
                n_acc     = upd_sum;
                if (parent == ROOT_NODE) begin
                    n_state = segsum_pkg::S_IDLE;
                end
            end
            segsum_pkg::S_QRUN: begin
                n_acc = acc_sum;
                if (r_a < r_b) begin
                    // odd left edge takes node a, odd right edge takes node b-1
                    mem_ra = r_a[AW-1:0];
                    mem_rb = b_dec[AW-1:0];
                    n_va   = r_a[0];
                    n_vb   = r_b[0];
                    n_a    = (r_a + BW'(r_a[0])) >> 1;
                    n_b    = (r_b - BW'(r_b[0])) >> 1;
                end else begin
                    n_va = 1'b0;
                    n_vb = 1'b0;
                    if (r_second) begin
                        n_second = 1'b0;
                        n_a      = LEAF_BASE_W;
                        n_b      = LEAF_BASE_W + BW'(r_hi) + BW'(1);
                    end else begin
                        n_res_sum = acc_sum;
                        n_res_err = 1'b0;
                        n_state   = segsum_pkg::S_OUT;
                    end
                end
            end
            segsum_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_res_sum;
                    n_out_err   = r_res_err;
                    n_state     = segsum_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = segsum_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= segsum_pkg::S_CLEAR;
            r_clr       <= '0;
            r_size      <= segsum_pkg::SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_size      <= n_size;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_p       <= n_p;
        r_acc     <= n_acc;
        r_a       <= n_a;
        r_b       <= n_b;
        r_va      <= n_va;
        r_vb      <= n_vb;
        r_second  <= n_second;
        r_res_sum <= n_res_sum;
        r_res_err <= n_res_err;
        r_out_sum <= n_out_sum;
        r_out_err <= n_out_err;
    end

    // node memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_nodes[mem_waddr] <= mem_wdata;
        end
        r_rd_a <= mem_nodes[mem_ra];
        r_rd_b <= mem_nodes[mem_rb];
    end

endmodule

### rtl/segsum_checker.sv
// Port-level assertions for segment_tree_range_sum, attached by bind.
// Depends on segsum_pkg.
module segsum_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [segsum_pkg::DATA_W-1:0]  o_range_sum,
    input logic                                  o_bound_error
);

    // flagged query carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bound_error |-> o_range_sum == '0)
        else $error("bound error word with nonzero sum");

    // one item at a time: the input is closed in the cycle after a word is accepted
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // a new result only comes while the input side is busy
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared from idle");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_range_sum) && $stable(o_bound_error))
        else $error("stalled output word changed");

endmodule

bind segment_tree_range_sum segsum_checker u_segsum_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_range_sum   (o_range_sum),
    .o_bound_error (o_bound_error)
);
